### design/bvm_pkg.sv
// shared types, opcodes and defaults for the byte machine execute unit
`timescale 1ns / 1ps

package bvm_pkg;

    localparam int DATA_DEPTH_DEF  = 4096;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int PC_WIDTH_DEF    = 16;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 32;

    localparam logic [7:0] OPC_ADD   = 8'h01;
    localparam logic [7:0] OPC_ADD3  = 8'h02;
    localparam logic [7:0] OPC_NOT   = 8'h03;
    localparam logic [7:0] OPC_STC   = 8'h04;
    localparam logic [7:0] OPC_PRINT = 8'h06;
    localparam logic [7:0] OPC_INC   = 8'h11;
    localparam logic [7:0] OPC_COPY  = 8'h31;
    localparam logic [7:0] OPC_ICOPY = 8'h32;
    localparam logic [7:0] OPC_CALL  = 8'h55;
    localparam logic [7:0] OPC_RET   = 8'h56;
    localparam logic [7:0] OPC_HALT  = 8'hEE;

    typedef enum logic [2:0] {
        STAT_OK    = 3'd0,
        STAT_HALT  = 3'd1,
        STAT_UNDER = 3'd2,
        STAT_OVER  = 3'd3,
        STAT_RANGE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_B,
        ST_RD_C,
        ST_PTR1,
        ST_PTR2,
        ST_PTR3,
        ST_PTR4,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [15:0] return_pc;
        logic [15:0] op_d;
        logic [15:0] op_c;
        logic [15:0] op_b;
        logic [15:0] op_a;
        logic [7:0]  opcode;
        logic [7:0]  preload_byte;
    } op_t;

    typedef struct packed {
        logic [2:0]  pad;
        logic [7:0]  char_out;
        logic        char_valid;
        logic [15:0] next_pc;
        logic        jump_valid;
        status_t     status;
    } result_t;

endpackage

### design/byte_vm_execute_unit.sv
// execute unit of the byte machine: data store, carry, return stack and sequencer
`timescale 1ns / 1ps
//
// takes one fetched instruction or preload byte per input transfer on the s_ channel
// and returns exactly one result transfer on the m_ channel for each of them.
// s_tuser set means preload: preload_byte goes to data address op_a.
// a one-entry input buffer takes the next transfer while the current one executes,
// and a result register holds the finished result until the receiver takes it.
// steps in the sequencer, bound by the single read port of the
// data memory (one byte read per cycle):
//   preload, stc, call, ret, halt, unknown, inc, not, copy, print : read op_a, then final
//   add : read a, read b, final    add3 : read a, b, c, final    indirect copy : four pointer bytes, then the target
// when the receiver stalls, the sequencer waits in its final step with nothing
// written, then the input buffer fills and s_tready drops.
// reset clears carry, stack pointer, buffer and result valid; the data memory
// and the return stack are not cleared and need no clearing pass.
//
module byte_vm_execute_unit
    import bvm_pkg::*;
#(
    parameter int DATA_DEPTH  = DATA_DEPTH_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int PC_WIDTH    = PC_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // preload_byte, opcode, op_a, op_b, op_c, op_d, return_pc
    input  logic [S_TDATA_W-1:0] s_tdata,
    // is_preload
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status, jump_valid, next_pc, char_valid, char_out, zero fill
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int AW  = $clog2(DATA_DEPTH);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam logic [16:0]  DEPTH17 = 17'(DATA_DEPTH);
    localparam logic [32:0]  DEPTH33 = 33'(DATA_DEPTH);
    localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

    state_t           state_reg, state_next;
    logic             buf_valid_reg, buf_valid_next;
    logic             buf_pre_reg;
    op_t              buf_op_reg;
    logic             w_pre_reg, w_pre_next;
    op_t              w_op_reg, w_op_next;
    logic [9:0]       acc_reg, acc_next;
    logic [23:0]      ptr_reg, ptr_next;
    logic             bad_reg, bad_next;
    logic [1:0]       carry_reg, carry_next;
    logic [SPW-1:0]   sp_reg, sp_next;
    logic             m_tvalid_reg, m_tvalid_next;
    result_t          m_res_reg, m_res_next;

    op_t              s_op;
    logic             s_xfer;
    logic             buf_take;
    logic             out_free;
    logic             load_res;
    result_t          res;

    logic             dat_we, dat_re;
    logic [AW-1:0]    dat_waddr, dat_raddr;
    logic [7:0]       dat_wdata, dat_rdata;
    logic             stk_we, stk_re;
    logic [SW-1:0]    stk_waddr, stk_raddr;
    logic [PC_WIDTH-1:0] stk_wdata, stk_rdata;

    logic             ok_a, ok_b, ok_c, ok_d, ok_a3;
    logic [16:0]      b_a3, a_p1, a_p2, a_p3;
    logic [31:0]      ptr_full;
    logic             ptr_ok;
    logic [9:0]       sum;
    logic [SPW-1:0]   sp_dec;
    logic [31:0]      a_ext, a_back, ret_ext, rpc_ext;
    logic [PC_WIDTH-1:0] a_pcw;

    assign s_op     = s_tdata;
    assign s_tready = !buf_valid_reg;
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_res_reg;

    assign b_a3  = {1'b0, buf_op_reg.op_a} + 17'd3;
    assign ok_a  = {1'b0, buf_op_reg.op_a} < DEPTH17;
    assign ok_b  = {1'b0, buf_op_reg.op_b} < DEPTH17;
    assign ok_c  = {1'b0, buf_op_reg.op_c} < DEPTH17;
    assign ok_d  = {1'b0, buf_op_reg.op_d} < DEPTH17;
    assign ok_a3 = b_a3 < DEPTH17;

    assign a_p1 = {1'b0, w_op_reg.op_a} + 17'd1;
    assign a_p2 = {1'b0, w_op_reg.op_a} + 17'd2;
    assign a_p3 = {1'b0, w_op_reg.op_a} + 17'd3;

    assign ptr_full = {dat_rdata, ptr_reg};
    assign ptr_ok   = {1'b0, ptr_full} < DEPTH33;
    assign sum      = acc_reg + {2'b00, dat_rdata};
    assign sp_dec   = sp_reg - 1'b1;

    assign a_ext   = 32'(w_op_reg.op_a);
    assign a_pcw   = a_ext[PC_WIDTH-1:0];
    assign a_back  = 32'(a_pcw);
    assign ret_ext = 32'(stk_rdata);
    assign rpc_ext = 32'(w_op_reg.return_pc);

    bvm_ram #(
        .WIDTH (8),
        .DEPTH (DATA_DEPTH)
    ) u_data_ram (
        .aclk    (aclk),
        .wr_en   (dat_we),
        .wr_addr (dat_waddr),
        .wr_data (dat_wdata),
        .rd_en   (dat_re),
        .rd_addr (dat_raddr),
        .rd_data (dat_rdata)
    );

    bvm_ram #(
        .WIDTH (PC_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_we),
        .wr_addr (stk_waddr),
        .wr_data (stk_wdata),
        .rd_en   (stk_re),
        .rd_addr (stk_raddr),
        .rd_data (stk_rdata)
    );

    always_comb begin
        state_next = state_reg;
        buf_take   = 1'b0;
        w_pre_next = w_pre_reg;
        w_op_next  = w_op_reg;
        acc_next   = acc_reg;
        ptr_next   = ptr_reg;
        bad_next   = bad_reg;
        carry_next = carry_reg;
        sp_next    = sp_reg;
        load_res   = 1'b0;
        res        = '0;
        dat_we     = 1'b0;
        dat_waddr  = '0;
        dat_wdata  = '0;
        dat_re     = 1'b0;
        dat_raddr  = '0;
        stk_we     = 1'b0;
        stk_waddr  = '0;
        stk_wdata  = '0;
        stk_re     = 1'b0;
        stk_raddr  = '0;

        case (state_reg)
            ST_IDLE: begin
                if (buf_valid_reg) begin
                    buf_take   = 1'b1;
                    w_pre_next = buf_pre_reg;
                    w_op_next  = buf_op_reg;
                    dat_re     = 1'b1;
                    dat_raddr  = buf_op_reg.op_a[AW-1:0];
                    stk_re     = 1'b1;
                    stk_raddr  = sp_dec[SW-1:0];
                    bad_next   = 1'b0;
                    state_next = ST_FIN;
                    if (buf_pre_reg) begin
                        bad_next = !ok_a;
                    end else begin
                        case (buf_op_reg.opcode)
                            OPC_ADD: begin
                                bad_next = !(ok_a && ok_b && ok_c);
                                if (ok_a && ok_b && ok_c) begin
                                    state_next = ST_RD_B;
                                end
                            end
                            OPC_ADD3: begin
                                bad_next = !(ok_a && ok_b && ok_c && ok_d);
                                if (ok_a && ok_b && ok_c && ok_d) begin
                                    state_next = ST_RD_B;
                                end
                            end
                            OPC_INC, OPC_NOT, OPC_STC, OPC_PRINT: begin
                                bad_next = !ok_a;
                            end
                            OPC_COPY: begin
                                bad_next = !(ok_a && ok_b);
                            end
                            OPC_ICOPY: begin
                                bad_next = !(ok_a3 && ok_b);
                                if (ok_a3 && ok_b) begin
                                    state_next = ST_PTR1;
                                end
                            end
                            default: begin
                                bad_next = 1'b0;
                            end
                        endcase
                    end
                end
            end
            ST_RD_B: begin
                acc_next   = {2'b00, dat_rdata};
                dat_re     = 1'b1;
                dat_raddr  = w_op_reg.op_b[AW-1:0];
                state_next = (w_op_reg.opcode == OPC_ADD3) ? ST_RD_C : ST_FIN;
            end
            ST_RD_C: begin
                acc_next   = sum;
                dat_re     = 1'b1;
                dat_raddr  = w_op_reg.op_c[AW-1:0];
                state_next = ST_FIN;
            end
            ST_PTR1: begin
                ptr_next[7:0] = dat_rdata;
                dat_re        = 1'b1;
                dat_raddr     = a_p1[AW-1:0];
                state_next    = ST_PTR2;
            end
            ST_PTR2: begin
                ptr_next[15:8] = dat_rdata;
                dat_re         = 1'b1;
                dat_raddr      = a_p2[AW-1:0];
                state_next     = ST_PTR3;
            end
            ST_PTR3: begin
                ptr_next[23:16] = dat_rdata;
                dat_re          = 1'b1;
                dat_raddr       = a_p3[AW-1:0];
                state_next      = ST_PTR4;
            end
            ST_PTR4: begin
                if (ptr_ok) begin
                    dat_re    = 1'b1;
                    dat_raddr = ptr_full[AW-1:0];
                end else begin
                    bad_next = 1'b1;
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    load_res   = 1'b1;
                    state_next = ST_IDLE;
                    if (bad_reg) begin
                        res.status = STAT_RANGE;
                    end else if (w_pre_reg) begin
                        dat_we    = 1'b1;
                        dat_waddr = w_op_reg.op_a[AW-1:0];
                        dat_wdata = w_op_reg.preload_byte;
                    end else begin
                        case (w_op_reg.opcode)
                            OPC_ADD: begin
                                dat_we     = 1'b1;
                                dat_waddr  = w_op_reg.op_c[AW-1:0];
                                dat_wdata  = sum[7:0];
                                carry_next = {1'b0, sum[8]};
                            end
                            OPC_ADD3: begin
                                dat_we     = 1'b1;
                                dat_waddr  = w_op_reg.op_d[AW-1:0];
                                dat_wdata  = sum[7:0];
                                carry_next = sum[9:8];
                            end
                            OPC_INC: begin
                                dat_we     = 1'b1;
                                dat_waddr  = w_op_reg.op_a[AW-1:0];
                                dat_wdata  = dat_rdata + 8'd1;
                                carry_next = 2'b00;
                            end
                            OPC_NOT: begin
                                dat_we     = 1'b1;
                                dat_waddr  = w_op_reg.op_a[AW-1:0];
                                dat_wdata  = ~dat_rdata;
                                carry_next = 2'b00;
                            end
                            OPC_COPY, OPC_ICOPY: begin
                                dat_we     = 1'b1;
                                dat_waddr  = w_op_reg.op_b[AW-1:0];
                                dat_wdata  = dat_rdata;
                                carry_next = 2'b00;
                            end
                            OPC_STC: begin
                                dat_we    = 1'b1;
                                dat_waddr = w_op_reg.op_a[AW-1:0];
                                dat_wdata = {6'b000000, carry_reg};
                            end
                            OPC_PRINT: begin
                                res.char_valid = 1'b1;
                                res.char_out   = dat_rdata;
                            end
                            OPC_CALL: begin
                                if (sp_reg >= SP_FULL) begin
                                    res.status = STAT_OVER;
                                end else begin
                                    stk_we         = 1'b1;
                                    stk_waddr      = sp_reg[SW-1:0];
                                    stk_wdata      = rpc_ext[PC_WIDTH-1:0];
                                    sp_next        = sp_reg + 1'b1;
                                    res.jump_valid = 1'b1;
                                    res.next_pc    = a_back[15:0];
                                    carry_next     = 2'b00;
                                end
                            end
                            OPC_RET: begin
                                if (sp_reg == '0) begin
                                    res.status = STAT_UNDER;
                                end else begin
                                    sp_next        = sp_dec;
                                    res.jump_valid = 1'b1;
                                    res.next_pc    = ret_ext[15:0];
                                    carry_next     = 2'b00;
                                end
                            end
                            OPC_HALT: begin
                                res.status = STAT_HALT;
                            end
                            default: begin
                                res.status = STAT_OK;
                            end
                        endcase
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        buf_valid_next = buf_valid_reg;
        if (s_xfer) begin
            buf_valid_next = 1'b1;
        end else if (buf_take) begin
            buf_valid_next = 1'b0;
        end
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (load_res) begin
            m_tvalid_next = 1'b1;
            m_res_next    = res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            buf_valid_reg <= 1'b0;
            carry_reg     <= 2'b00;
            sp_reg        <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            buf_valid_reg <= buf_valid_next;
            carry_reg     <= carry_next;
            sp_reg        <= sp_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            buf_pre_reg <= s_tuser;
            buf_op_reg  <= s_op;
        end
        w_pre_reg <= w_pre_next;
        w_op_reg  <= w_op_next;
        acc_reg   <= acc_next;
        ptr_reg   <= ptr_next;
        bad_reg   <= bad_next;
        m_res_reg <= m_res_next;
    end

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_FULL)
        else $error("stack pointer beyond stack depth");

    a_write_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        dat_we |-> (state_reg == ST_FIN && out_free))
        else $error("data write outside final step");

    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && buf_valid_reg) |=> (!buf_valid_reg && state_reg != ST_IDLE))
        else $error("buffered transfer not taken by sequencer");

    a_fin_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && !out_free) |=> (state_reg == ST_FIN && m_tvalid_reg))
        else $error("final step left while result register busy");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("result produced outside final step");
`endif

endmodule

### design/bvm_ram.sv
// generic single-clock ram, one write port and one registered read port
`timescale 1ns / 1ps

module bvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### test/byte_vm_execute_unit_checker.sv
// checker for the byte machine execute unit: tracks transfers, predicts and compares results
`timescale 1ns / 1ps

module byte_vm_execute_unit_checker
    import bvm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   results_due,
    output int                   fail_count
);

    logic [7:0]  data_mem [DATA_DEPTH_DEF];
    logic [1:0]  carry;
    logic [15:0] ret_stack [STACK_DEPTH_DEF];
    int          stack_fill;
    result_t     due_results [$];

    function automatic bit in_store(input logic [31:0] addr);
        return addr < DATA_DEPTH_DEF;
    endfunction

    task automatic predict_result(input logic preload, input op_t op, output result_t res);
        logic [9:0]  sum;
        logic [31:0] ptr;
        res = '0;
        res.status = STAT_OK;
        if (preload) begin
            if (in_store(op.op_a)) begin
                data_mem[op.op_a] = op.preload_byte;
            end else begin
                res.status = STAT_RANGE;
            end
        end else begin
            case (op.opcode)
                OPC_ADD: begin
                    if (in_store(op.op_a) && in_store(op.op_b) && in_store(op.op_c)) begin
                        sum = 10'(data_mem[op.op_a]) + 10'(data_mem[op.op_b]);
                        data_mem[op.op_c] = sum[7:0];
                        carry = sum[9:8];
                    end else begin
                        res.status = STAT_RANGE;
                    end
                end
                OPC_ADD3: begin
                    if (in_store(op.op_a) && in_store(op.op_b) && in_store(op.op_c)
                            && in_store(op.op_d)) begin
                        sum = 10'(data_mem[op.op_a]) + 10'(data_mem[op.op_b])
                            + 10'(data_mem[op.op_c]);
                        data_mem[op.op_d] = sum[7:0];
                        carry = sum[9:8];
                    end else begin
                        res.status = STAT_RANGE;
                    end
                end
                OPC_INC: begin
                    if (in_store(op.op_a)) begin
                        data_mem[op.op_a] = data_mem[op.op_a] + 8'd1;
                        carry = '0;
                    end else begin
                        res.status = STAT_RANGE;
                    end
                end
                OPC_NOT: begin
                    if (in_store(op.op_a)) begin
                        data_mem[op.op_a] = ~data_mem[op.op_a];
                        carry = '0;
                    end else begin
                        res.status = STAT_RANGE;
                    end
                end
                OPC_COPY: begin
                    if (in_store(op.op_a) && in_store(op.op_b)) begin
                        data_mem[op.op_b] = data_mem[op.op_a];
                        carry = '0;
                    end else begin
                        res.status = STAT_RANGE;
                    end
                end
                OPC_ICOPY: begin
                    if (in_store(32'(op.op_a) + 32'd3) && in_store(op.op_b)) begin
                        ptr = {data_mem[op.op_a + 16'd3], data_mem[op.op_a + 16'd2],
                               data_mem[op.op_a + 16'd1], data_mem[op.op_a]};
                        if (in_store(ptr)) begin
                            data_mem[op.op_b] = data_mem[ptr];
                            carry = '0;
                        end else begin
                            res.status = STAT_RANGE;
                        end
                    end else begin
                        res.status = STAT_RANGE;
                    end
                end
                OPC_STC: begin
                    if (in_store(op.op_a)) begin
                        data_mem[op.op_a] = {6'd0, carry};
                    end else begin
                        res.status = STAT_RANGE;
                    end
                end
                OPC_PRINT: begin
                    if (in_store(op.op_a)) begin
                        res.char_valid = 1'b1;
                        res.char_out   = data_mem[op.op_a];
                    end else begin
                        res.status = STAT_RANGE;
                    end
                end
                OPC_CALL: begin
                    if (stack_fill >= STACK_DEPTH_DEF) begin
                        res.status = STAT_OVER;
                    end else begin
                        ret_stack[stack_fill] = op.return_pc;
                        stack_fill++;
                        res.jump_valid = 1'b1;
                        res.next_pc    = op.op_a;
                        carry = '0;
                    end
                end
                OPC_RET: begin
                    if (stack_fill == 0) begin
                        res.status = STAT_UNDER;
                    end else begin
                        stack_fill--;
                        res.jump_valid = 1'b1;
                        res.next_pc    = ret_stack[stack_fill];
                        carry = '0;
                    end
                end
                OPC_HALT: begin
                    res.status = STAT_HALT;
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            fail_count++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endtask

    always @(posedge aclk) begin : xfer_watch
        result_t got;
        result_t want;
        if (!aresetn) begin
            carry      = '0;
            stack_fill = 0;
            fail_count = 0;
            due_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (due_results.size() == 0) begin
                    fail_count++;
                    $error("result transfer with nothing expected: %h", m_tdata);
                end else begin
                    want = due_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("jump_valid", want.jump_valid, got.jump_valid);
                    check_field("next_pc", want.next_pc, got.next_pc);
                    check_field("char_valid", want.char_valid, got.char_valid);
                    check_field("char_out", want.char_out, got.char_out);
                end
            end
            if (s_tvalid && s_tready) begin
                predict_result(s_tuser, op_t'(s_tdata), want);
                due_results.push_back(want);
            end
        end
        results_due <= due_results.size();
    end

endmodule

### test/byte_vm_execute_unit_tb.sv
// testbench top for the byte machine execute unit: stimulus, flow control and verdict
`timescale 1ns / 1ps

module byte_vm_execute_unit_tb;
    import bvm_pkg::*;

    localparam int ITEMS_PER_PHASE = 138;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int results_due;
    int fail_count;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int useful_items       = 0;

    bit          written_map [DATA_DEPTH_DEF];
    logic [15:0] written_list [$];

    byte_vm_execute_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    byte_vm_execute_unit_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .results_due (results_due),
        .fail_count  (fail_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    function automatic bit known_opcode(input logic [7:0] opc);
        case (opc)
            OPC_ADD, OPC_ADD3, OPC_NOT, OPC_STC, OPC_PRINT, OPC_INC,
            OPC_COPY, OPC_ICOPY, OPC_CALL, OPC_RET, OPC_HALT: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] stray_opcode();
        logic [7:0] opc;
        do opc = 8'($urandom); while (known_opcode(opc));
        return opc;
    endfunction

    function automatic logic [15:0] any16();
        return 16'($urandom);
    endfunction

    // mostly a small window so that results get reused
    function automatic logic [15:0] fresh_addr();
        if ($urandom_range(0, 3) != 0) begin
            return 16'($urandom_range(0, 63));
        end
        return 16'($urandom_range(0, DATA_DEPTH_DEF - 1));
    endfunction

    function automatic logic [15:0] known_addr();
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    function automatic logic [15:0] spoil(input bit hit, input logic [15:0] addr);
        return hit ? 16'($urandom_range(DATA_DEPTH_DEF, 65535)) : addr;
    endfunction

    task automatic note_write(input logic [15:0] addr);
        if (!written_map[addr]) begin
            written_map[addr] = 1'b1;
            written_list.push_back(addr);
        end
    endtask

    task automatic send_item(input logic preload, input op_t op);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= op;
        s_tuser  <= preload;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (preload || known_opcode(op.opcode)) begin
            useful_items++;
        end
    endtask

    task automatic preload(input logic [15:0] addr, input logic [7:0] val);
        op_t op;
        op = op_t'({$urandom, $urandom, $urandom});
        op.op_a         = addr;
        op.preload_byte = val;
        if (addr < DATA_DEPTH_DEF) begin
            note_write(addr);
        end
        send_item(1'b1, op);
    endtask

    task automatic instr(input logic [7:0] opc, input logic [15:0] a, input logic [15:0] b,
                         input logic [15:0] c, input logic [15:0] d, input logic [15:0] rpc);
        op_t op;
        op = op_t'({$urandom, $urandom, $urandom});
        op.opcode    = opc;
        op.op_a      = a;
        op.op_b      = b;
        op.op_c      = c;
        op.op_d      = d;
        op.return_pc = rpc;
        send_item(1'b0, op);
    endtask

    // wait with the input channel quiet until every result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
    endtask

    task automatic directed_items();
        instr(OPC_RET, any16(), any16(), any16(), any16(), any16());
        instr(OPC_STC, 16'd0, any16(), any16(), any16(), any16());
        note_write(16'd0);
        preload(16'd1, 8'hFF);
        preload(16'd2, 8'hFF);
        preload(16'(DATA_DEPTH_DEF - 1), 8'h80);
        preload(16'hFFFF, 8'h00);
        preload(16'(DATA_DEPTH_DEF), 8'h5A);
        instr(OPC_ADD, 16'd1, 16'd2, 16'd3, any16(), any16());
        note_write(16'd3);
        instr(OPC_STC, 16'd4, any16(), any16(), any16(), any16());
        note_write(16'd4);
        instr(OPC_ADD3, 16'd1, 16'd2, 16'(DATA_DEPTH_DEF - 1), 16'd5, any16());
        note_write(16'd5);
        instr(OPC_STC, 16'd6, any16(), any16(), any16(), any16());
        note_write(16'd6);
        instr(OPC_INC, 16'd1, any16(), any16(), any16(), any16());
        instr(OPC_NOT, 16'd3, any16(), any16(), any16(), any16());
        instr(OPC_COPY, 16'(DATA_DEPTH_DEF - 1), 16'd7, any16(), any16(), any16());
        note_write(16'd7);
        // pointer to the top data entry
        preload(16'd8, 8'hFF);
        preload(16'd9, 8'h0F);
        preload(16'd10, 8'h00);
        preload(16'd11, 8'h00);
        instr(OPC_ICOPY, 16'd8, 16'd12, any16(), any16(), any16());
        note_write(16'd12);
        instr(OPC_ICOPY, 16'(DATA_DEPTH_DEF - 3), 16'd13, any16(), any16(), any16());
        instr(OPC_PRINT, 16'd12, any16(), any16(), any16(), any16());
        instr(OPC_CALL, 16'hFFFF, any16(), any16(), any16(), 16'h0000);
        instr(OPC_CALL, 16'h0000, any16(), any16(), any16(), 16'hFFFF);
        instr(OPC_RET, any16(), any16(), any16(), any16(), any16());
        instr(OPC_RET, any16(), any16(), any16(), any16(), any16());
        instr(OPC_HALT, any16(), any16(), any16(), any16(), any16());
        instr(8'h00, any16(), any16(), any16(), any16(), any16());
        instr(8'hFF, any16(), any16(), any16(), any16(), any16());
        instr(OPC_ADD, 16'd1, 16'd2, 16'hFFFF, any16(), any16());
    endtask

    task automatic random_instr();
        int          pick;
        int          bad;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] d;
        logic [31:0] ptr;
        pick = $urandom_range(0, 99);
        bad  = -1;
        if ($urandom_range(0, 9) == 0) begin
            bad = $urandom_range(0, 3);
        end
        a = known_addr();
        b = known_addr();
        c = known_addr();
        d = fresh_addr();
        if (pick < 18) begin
            preload(spoil(bad >= 0, fresh_addr()), 8'($urandom));
        end else if (pick < 28) begin
            c = spoil(bad >= 2, fresh_addr());
            instr(OPC_ADD, spoil(bad == 0, a), spoil(bad == 1, b), c, any16(), any16());
            if (bad < 0) begin
                note_write(c);
            end
        end else if (pick < 36) begin
            d = spoil(bad == 3, d);
            instr(OPC_ADD3, spoil(bad == 0, a), spoil(bad == 1, b), spoil(bad == 2, c), d,
                  any16());
            if (bad < 0) begin
                note_write(d);
            end
        end else if (pick < 42) begin
            instr(OPC_INC, spoil(bad >= 0, a), any16(), any16(), any16(), any16());
        end else if (pick < 48) begin
            instr(OPC_NOT, spoil(bad >= 0, a), any16(), any16(), any16(), any16());
        end else if (pick < 55) begin
            b = spoil(bad > 0, fresh_addr());
            instr(OPC_COPY, spoil(bad == 0, a), b, any16(), any16(), any16());
            if (bad < 0) begin
                note_write(b);
            end
        end else if (pick < 61) begin
            a = spoil(bad >= 0, fresh_addr());
            instr(OPC_STC, a, any16(), any16(), any16(), any16());
            if (bad < 0) begin
                note_write(a);
            end
        end else if (pick < 68) begin
            instr(OPC_PRINT, spoil(bad >= 0, a), any16(), any16(), any16(), any16());
        end else if (pick < 76) begin
            if (bad == 0) begin
                instr(OPC_ICOPY, 16'($urandom_range(DATA_DEPTH_DEF - 3, 65535)), fresh_addr(),
                      any16(), any16(), any16());
            end else begin
                // lay down the pointer bytes right before the indirect copy
                a = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 60))
                                                : 16'($urandom_range(0, DATA_DEPTH_DEF - 4));
                ptr = ($urandom_range(0, 4) != 0) ? 32'(known_addr())
                                                  : ($urandom | 32'h0000_1000);
                for (int i = 0; i < 4; i++) begin
                    preload(a + 16'(i), ptr[8*i +: 8]);
                end
                b = spoil(bad > 0, fresh_addr());
                instr(OPC_ICOPY, a, b, any16(), any16(), any16());
                if (bad < 0 && ptr < DATA_DEPTH_DEF) begin
                    note_write(b);
                end
            end
        end else if (pick < 79) begin
            // nested calls that can go deep enough to hit overflow, then returns that can unwind past empty
            repeat ($urandom_range(1, 18)) begin
                instr(OPC_CALL, any16(), any16(), any16(), any16(), any16());
            end
            repeat ($urandom_range(1, 18)) begin
                instr(OPC_RET, any16(), any16(), any16(), any16(), any16());
            end
        end else if (pick < 84) begin
            instr(OPC_CALL, any16(), any16(), any16(), any16(), any16());
        end else if (pick < 89) begin
            instr(OPC_RET, any16(), any16(), any16(), any16(), any16());
        end else if (pick < 92) begin
            instr(OPC_HALT, any16(), any16(), any16(), any16(), any16());
        end else if ($urandom_range(0, 1) != 0) begin
            preload(any16(), 8'($urandom));
        end else begin
            instr(stray_opcode(), any16(), any16(), any16(), any16(), any16());
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        directed_items();
        drain();
        useful_items = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 67;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 67;
                end
                default: begin
                    sender_idle_pct    = 7;
                    receiver_stall_pct = 7;
                end
            endcase
            while (useful_items < (ph + 1) * ITEMS_PER_PHASE) random_instr();
            drain();
        end
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
design/bvm_pkg.sv
design/bvm_ram.sv
design/byte_vm_execute_unit.sv
test/byte_vm_execute_unit_checker.sv
test/byte_vm_execute_unit_tb.sv
